/* sv/stepper_step_dir_generator_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the stepper step/dir generator
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef STEPPER_STEP_DIR_GENERATOR_UNIT_DEFINES_SVH
`define STEPPER_STEP_DIR_GENERATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked only outside reset
`define SSDG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included
`define SSDG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SSDG_ASSERT(lbl, clk, rstn, prop, msg)

`define SSDG_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/ssdg_pkg.sv */
// ----------------------------------------------------------------------------
// ssdg_pkg
// Shared types and constants of the stepper step/dir generator.
// ----------------------------------------------------------------------------
package ssdg_pkg;

    // Number of motors in use (1 to 3); result ports always have three channels
    localparam int NUM_MOTORS = 3;
    localparam int CHANNELS   = 3;
    localparam int MOT_W      = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    localparam int TICK_W  = 32;
    localparam int POS_W   = 32;
    localparam int DIV_W   = 16;
    localparam int STEPS_W = 16;
    localparam int IDX_W   = 2;
    localparam int CNT_W   = $clog2(TICK_W);

    // Request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_MOVE = 1'b1;

    // Direction levels
    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    typedef logic [MOT_W-1:0] t_mot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_APPLY,
        S_NEXT,
        S_TICK,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic move_en;
        logic div_start;
        logic div_step;
        logic apply;
        logic tick_end;
        logic out_load;
        t_mot motor;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_zero;
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

/* sv/ssdg_if.sv */
// ----------------------------------------------------------------------------
// ssdg interfaces
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssdg_req_if;
    import ssdg_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [IDX_W-1:0]   motor_index;
    logic signed [STEPS_W-1:0] move_steps;

    modport source (output valid, req_type, motor_index, move_steps, input ready);
    modport sink   (input valid, req_type, motor_index, move_steps, output ready);
endinterface

interface ssdg_res_if;
    logic valid;
    logic ready;
    logic step_pin_0;
    logic step_pin_1;
    logic step_pin_2;
    logic dir_pin_0;
    logic dir_pin_1;
    logic dir_pin_2;
    logic done_0;
    logic done_1;
    logic done_2;

    modport source (output valid, step_pin_0, step_pin_1, step_pin_2,
                    dir_pin_0, dir_pin_1, dir_pin_2, done_0, done_1, done_2,
                    input ready);
    modport sink   (input valid, step_pin_0, step_pin_1, step_pin_2,
                    dir_pin_0, dir_pin_1, dir_pin_2, done_0, done_1, done_2,
                    output ready);
endinterface

interface ssdg_cfg_if;
    import ssdg_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] reg_index;
    logic [DIV_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* sv/stepper_step_dir_generator_unit.sv */
// ----------------------------------------------------------------------------
// stepper_step_dir_generator_unit
// Step/dir pulse generator for up to three stepper motors on one tick counter.
// ----------------------------------------------------------------------------
// A move transaction goes from S_IDLE straight to S_OUT, which loads its result
// into the output register once that register is free. In a tick transaction
// each motor with a nonzero divider passes through one shared radix-2 divider
// that computes tick_count / divider, then through the decision and bookkeeping
// states; a motor with a zero divider skips the divider. Items are handled one
// at a time; the next item is accepted while a result waits in the output
// register. Divider writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module stepper_step_dir_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssdg_req_if.sink    i_req,
    ssdg_res_if.source  o_res,
    ssdg_cfg_if.sink    i_cfg
);
    import ssdg_pkg::*;

    t_dp_cmd             cmd;
    t_dp_sts             sts;
    logic [CHANNELS-1:0] step;
    logic [CHANNELS-1:0] dir;
    logic [CHANNELS-1:0] done;

    // Controller
    ssdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_req_type (i_req.req_type),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Datapath
    ssdg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_motor_index (i_req.motor_index),
        .i_move_steps  (i_req.move_steps),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.reg_index),
        .i_cfg_data    (i_cfg.wdata),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_step        (step),
        .o_dir         (dir),
        .o_done        (done)
    );

    assign i_cfg.ready = 1'b1;

    assign o_res.step_pin_0 = step[0];
    assign o_res.step_pin_1 = step[1];
    assign o_res.step_pin_2 = step[2];
    assign o_res.dir_pin_0  = dir[0];
    assign o_res.dir_pin_1  = dir[1];
    assign o_res.dir_pin_2  = dir[2];
    assign o_res.done_0     = done[0];
    assign o_res.done_1     = done[1];
    assign o_res.done_2     = done[2];

endmodule

/* sv/ssdg_div.sv */
// ----------------------------------------------------------------------------
// ssdg_div
// Restoring radix-2 divider: 32 / 16 bits, one bit a cycle while i_step is high.
// ----------------------------------------------------------------------------
module ssdg_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_step,
    input  logic [ssdg_pkg::TICK_W-1:0] i_dividend,
    input  logic [ssdg_pkg::DIV_W-1:0]  i_divisor,
    output logic [ssdg_pkg::TICK_W-1:0] o_quotient,
    output logic [ssdg_pkg::DIV_W-1:0]  o_remainder,
    output logic                       o_last
);
    import ssdg_pkg::*;

    logic [TICK_W-1:0] r_quo;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsr;
    logic [CNT_W-1:0]  r_cnt;

    logic [DIV_W:0]    trial;
    logic              fits;
    logic [DIV_W:0]    diff;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        trial = {r_rem, r_quo[TICK_W-1]};
        diff  = trial - {1'b0, r_dsr};
        fits  = (trial >= {1'b0, r_dsr});
    end

    // Iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Quotient shifts in from the bottom as the dividend shifts out the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (i_step) begin
            r_quo <= {r_quo[TICK_W-2:0], fits};
            r_rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_last      = (r_cnt == CNT_W'(TICK_W - 1));

endmodule

/* sv/ssdg_dp.sv */
// ----------------------------------------------------------------------------
// ssdg_dp
// Datapath: dividers, tick counter, motor state, shared divider, result register.
// ----------------------------------------------------------------------------
`include "stepper_step_dir_generator_unit_defines.svh"

module ssdg_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssdg_pkg::t_dp_cmd             i_cmd,
    output ssdg_pkg::t_dp_sts             o_sts,
    input  logic [ssdg_pkg::IDX_W-1:0]    i_motor_index,
    input  logic signed [ssdg_pkg::STEPS_W-1:0] i_move_steps,
    input  logic                          i_cfg_we,
    input  logic [ssdg_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [ssdg_pkg::DIV_W-1:0]    i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [ssdg_pkg::CHANNELS-1:0] o_step,
    output logic [ssdg_pkg::CHANNELS-1:0] o_dir,
    output logic [ssdg_pkg::CHANNELS-1:0] o_done
);
    import ssdg_pkg::*;

    logic [DIV_W-1:0]  r_div  [NUM_MOTORS];
    logic [TICK_W-1:0] r_tick;
    logic [POS_W-1:0]  r_pos  [NUM_MOTORS];
    logic [POS_W-1:0]  r_tgt  [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] r_step;
    logic [NUM_MOTORS-1:0] r_dir;
    logic [NUM_MOTORS-1:0] r_done;

    logic                r_out_valid;
    logic [CHANNELS-1:0] r_out_step;
    logic [CHANNELS-1:0] r_out_dir;
    logic [CHANNELS-1:0] r_out_done;

    logic [TICK_W-1:0] quo;
    logic [DIV_W-1:0]  rem;
    logic              div_last;

    logic [POS_W-1:0]  cur_pos;
    logic [POS_W-1:0]  cur_tgt;
    logic              go_up;
    logic              go_down;
    logic [POS_W-1:0]  move_delta;
    logic              move_live;
    t_mot              move_mot;

    logic [CHANNELS-1:0] live_step;
    logic [CHANNELS-1:0] live_dir;
    logic [CHANNELS-1:0] live_done;

    // Shared divider: tick_count / divider of the selected motor
    ssdg_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_step      (i_cmd.div_step),
        .i_dividend  (r_tick),
        .i_divisor   (r_div[i_cmd.motor]),
        .o_quotient  (quo),
        .o_remainder (rem),
        .o_last      (div_last)
    );

    // Step decision for the selected motor
    always_comb begin
        cur_pos = r_pos[i_cmd.motor];
        cur_tgt = r_tgt[i_cmd.motor];
        go_up   = ($signed(cur_pos) < $signed(cur_tgt));
        go_down = ($signed(cur_tgt) < $signed(cur_pos));
    end

    // Move command: target = position + 2 * steps
    always_comb begin
        move_delta = {{(POS_W - STEPS_W - 1){i_move_steps[STEPS_W-1]}}, i_move_steps, 1'b0};
        move_live  = (i_motor_index < IDX_W'(NUM_MOTORS));
        move_mot   = i_motor_index[MOT_W-1:0];
    end

    // Divider registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NUM_MOTORS; m++) begin
                r_div[m] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_index < IDX_W'(NUM_MOTORS))) begin
            r_div[i_cfg_index[MOT_W-1:0]] <= i_cfg_data;
        end
    end

    // Tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (i_cmd.tick_end) begin
            r_tick <= r_tick + TICK_W'(1);
        end
    end

    // Motor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NUM_MOTORS; m++) begin
                r_pos[m] <= '0;
                r_tgt[m] <= '0;
            end
            r_step <= '0;
            r_dir  <= '0;
            r_done <= '0;
        end else begin
            if (i_cmd.move_en && move_live) begin
                r_tgt[move_mot]  <= r_pos[move_mot] + move_delta;
                r_done[move_mot] <= 1'b0;
            end
            if (i_cmd.apply && (rem == '0) && (go_up || go_down)) begin
                r_step[i_cmd.motor] <= quo[0];
                r_dir[i_cmd.motor]  <= go_up ? DIR_UP : DIR_DOWN;
                r_pos[i_cmd.motor]  <= go_up ? (cur_pos + POS_W'(1)) : (cur_pos - POS_W'(1));
            end
            if (i_cmd.tick_end) begin
                for (int m = 0; m < NUM_MOTORS; m++) begin
                    if (r_pos[m] == r_tgt[m]) begin
                        r_done[m] <= 1'b1;
                    end
                end
            end
        end
    end

    // Channels beyond the motor count report zero
    for (genvar g = 0; g < CHANNELS; g++) begin : g_live
        if (g < NUM_MOTORS) begin : g_on
            assign live_step[g] = r_step[g];
            assign live_dir[g]  = r_dir[g];
            assign live_done[g] = r_done[g];
        end else begin : g_off
            assign live_step[g] = 1'b0;
            assign live_dir[g]  = 1'b0;
            assign live_done[g] = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_step <= live_step;
            r_out_dir  <= live_dir;
            r_out_done <= live_done;
        end
    end

    assign o_sts.div_zero = (r_div[i_cmd.motor] == '0);
    assign o_sts.div_last = div_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_step      = r_out_step;
    assign o_dir       = r_out_dir;
    assign o_done      = r_out_done;

    // The shared divider never runs on a zero divisor
    `SSDG_ASSERT(a_div_nonzero, i_clk, i_rst_n, i_cmd.div_start |-> (r_div[i_cmd.motor] != '0), "divider started with zero divisor")
    // A loaded result is offered at the next edge
    `SSDG_ASSERT(a_out_shown, i_clk, i_rst_n, i_cmd.out_load |=> r_out_valid, "result load lost")
    // The tick counter only moves at the end of a tick transaction
    `SSDG_ASSERT(a_tick_hold, i_clk, i_rst_n, !i_cmd.tick_end |=> (r_tick == $past(r_tick)), "tick counter moved outside tick end")
    // A result is never overwritten while it waits
    `SSDG_ASSERT(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load |-> (!r_out_valid || i_out_ready), "pending result overwritten")

endmodule

/* sv/ssdg_ctrl.sv */
// ----------------------------------------------------------------------------
// ssdg_ctrl
// Controller: moves, and ticks over the motors through the shared divider.
// ----------------------------------------------------------------------------
module ssdg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    output logic              o_in_ready,
    output ssdg_pkg::t_dp_cmd o_cmd,
    input  ssdg_pkg::t_dp_sts i_sts
);
    import ssdg_pkg::*;

    t_state r_state;
    t_state n_state;
    t_mot   r_motor;
    t_mot   n_motor;
    logic   last_motor;

    assign last_motor = (r_motor == MOT_W'(NUM_MOTORS - 1));

    // State and motor counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_motor <= '0;
        end else begin
            r_state <= n_state;
            r_motor <= n_motor;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_motor = r_motor;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_motor = '0;
                    n_state = (i_req_type == REQ_TICK) ? S_CHECK : S_OUT;
                end
            end
            S_CHECK: begin
                n_state = i_sts.div_zero ? S_NEXT : S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (last_motor) begin
                    n_state = S_TICK;
                end else begin
                    n_motor = r_motor + MOT_W'(1);
                    n_state = S_CHECK;
                end
            end
            S_TICK: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.motor     = r_motor;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.move_en = i_in_valid && (i_req_type == REQ_MOVE);
            end
            S_CHECK: begin
                o_cmd.div_start = !i_sts.div_zero;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
            end
            S_NEXT: begin
            end
            S_TICK: begin
                o_cmd.tick_end = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule
